>>> design/rbs_pkg.sv
// Package for the record bubble sort block: field widths, defaults,
// and the command and status structs between controller and datapath.
// No dependencies.
package rbs_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 6;
    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_BITS_DEF = 16;

    typedef struct packed {
        logic load;
        logic load_last;
        logic pass_rd;
        logic flush;
        logic emit_rd;
        logic emit_cap;
    } dp_cmd_t;

    typedef struct packed {
        logic nonempty;
        logic ptr_end;
        logic top_gt2;
        logic emit_last;
    } dp_status_t;

endpackage

>>> design/rbs_if.sv
// Valid/ready channel interfaces for the record bubble sort block.
// Depends on rbs_pkg for the field widths.
interface rbs_in_if;
    import rbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_record;

    modport source (output valid, output sort_key, output record_tag,
                    output last_record, input ready);
    modport sink (input valid, input sort_key, input record_tag,
                  input last_record, output ready);
endinterface

interface rbs_out_if;
    import rbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             final_output;

    modport source (output valid, output sorted_key, output sorted_tag,
                    output final_output, input ready);
    modport sink (input valid, input sorted_key, input sorted_tag,
                  input final_output, output ready);
endinterface

>>> design/rbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> design/rbs_ctrl.sv
// Controller state machine for the record bubble sort block.
// Depends on rbs_pkg for the command and status structs.
module rbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rbs_pkg::dp_status_t status,
    output rbs_pkg::dp_cmd_t    cmd
);
    import rbs_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD      = 6'b000001,
        S_PASS      = 6'b000010,
        S_FLUSH     = 6'b000100,
        S_EMIT_RD   = 6'b001000,
        S_EMIT_WAIT = 6'b010000,
        S_EMIT_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT_OUT);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        cmd.load      = in_fire;
        cmd.load_last = in_fire && in_last;
        cmd.pass_rd   = (state_reg == S_PASS) && !status.ptr_end;
        cmd.flush     = (state_reg == S_FLUSH);
        cmd.emit_rd   = (state_reg == S_EMIT_RD);
        cmd.emit_cap  = (state_reg == S_EMIT_WAIT);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire && in_last)
                begin
                    state_next = status.nonempty ? S_PASS : S_EMIT_RD;
                end
            end
            S_PASS:
            begin
                if (status.ptr_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = status.top_gt2 ? S_PASS : S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    state_next = status.emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> design/rbs_datapath.sv
// Datapath for the record bubble sort block: record store, counters,
// the bubble carry register and the output register.
// Depends on rbs_pkg and rbs_ram.
module rbs_datapath #(
    parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF,
    parameter int KEY_BITS    = rbs_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rbs_pkg::dp_cmd_t            cmd,
    output rbs_pkg::dp_status_t         status,
    input  logic [rbs_pkg::KEY_W-1:0]   in_key,
    input  logic [rbs_pkg::TAG_W-1:0]   in_tag,
    output logic [rbs_pkg::KEY_W-1:0]   out_key,
    output logic [rbs_pkg::TAG_W-1:0]   out_tag,
    output logic                        out_final
);
    import rbs_pkg::*;

    localparam int CntW  = $clog2(MAX_RECORDS + 1);
    localparam int IdxW  = $clog2(MAX_RECORDS);
    localparam int SkW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int RamW  = SkW + TAG_W;

    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] n_reg, n_next;
    logic [CntW-1:0] top_reg, top_next;
    logic [CntW-1:0] ptr_reg, ptr_next;
    logic            dv_reg;
    logic [IdxW-1:0] didx_reg;
    logic [RamW-1:0] carry_reg, carry_next;
    logic [SkW-1:0]  out_key_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic            out_final_reg;

    logic            stored;
    logic [CntW-1:0] n_load;
    logic [CntW-1:0] top_m1;
    logic [RamW-1:0] rdata;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [RamW-1:0] wdata;
    logic            re;
    logic            carry_gt;

    assign stored   = (count_reg < CntW'(MAX_RECORDS));
    assign n_load   = count_reg + CntW'(stored);
    assign top_m1   = top_reg - CntW'(1);
    assign carry_gt = (carry_reg[RamW-1:TAG_W] > rdata[RamW-1:TAG_W]);

    assign status.nonempty  = (count_reg != '0);
    assign status.ptr_end   = (ptr_reg == top_reg);
    assign status.top_gt2   = (top_reg > CntW'(2));
    assign status.emit_last = (ptr_reg == n_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[IdxW-1:0];
        wdata = {in_key[SkW-1:0], in_tag};
        if (cmd.load && stored)
        begin
            we = 1'b1;
        end
        else if (dv_reg && (didx_reg != '0))
        begin
            we    = 1'b1;
            waddr = didx_reg - IdxW'(1);
            wdata = carry_gt ? rdata : carry_reg;
        end
        else if (cmd.flush)
        begin
            we    = 1'b1;
            waddr = top_m1[IdxW-1:0];
            wdata = carry_reg;
        end
    end

    assign re = cmd.pass_rd || cmd.emit_rd;

    rbs_ram #(
        .WIDTH (RamW),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (ptr_reg[IdxW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        n_next     = n_reg;
        top_next   = top_reg;
        ptr_next   = ptr_reg;
        carry_next = carry_reg;
        if (cmd.load_last)
        begin
            count_next = '0;
            n_next     = n_load;
            top_next   = n_load;
            ptr_next   = '0;
        end
        else if (cmd.load && stored)
        begin
            count_next = count_reg + CntW'(1);
        end
        if (cmd.flush)
        begin
            top_next = top_m1;
            ptr_next = '0;
        end
        else if (re)
        begin
            ptr_next = ptr_reg + CntW'(1);
        end
        if (dv_reg && ((didx_reg == '0) || !carry_gt))
        begin
            carry_next = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            n_reg     <= '0;
            top_reg   <= '0;
            ptr_reg   <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            n_reg     <= n_next;
            top_reg   <= top_next;
            ptr_reg   <= ptr_next;
            dv_reg    <= cmd.pass_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.pass_rd)
        begin
            didx_reg <= ptr_reg[IdxW-1:0];
        end
        if (cmd.emit_cap)
        begin
            out_key_reg   <= rdata[RamW-1:TAG_W];
            out_tag_reg   <= rdata[TAG_W-1:0];
            out_final_reg <= (ptr_reg == n_reg);
        end
    end

    assign out_key   = KEY_W'(out_key_reg);
    assign out_tag   = out_tag_reg;
    assign out_final = out_final_reg;
endmodule

>>> design/record_bubble_sort_by_key.sv
// Channel    | Direction | Payload
// rec_in     | sink      | sort_key, record_tag, last_record
// rec_out    | source    | sorted_key, sorted_tag, final_output
//
// Records load at one per cycle. After the last record, the sort makes n - 1
// passes over the record RAM; the pass over the first m records reads each of
// those entries once through the single read port.
// Each sorted record is then read from the RAM, registered and held until ready.
// Reset is asynchronous and clears only control state; no RAM clear pass.
// Depends on rbs_pkg, rbs_if, rbs_ram, rbs_ctrl and rbs_datapath.
module record_bubble_sort_by_key #(
    parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF,
    parameter int KEY_BITS    = rbs_pkg::KEY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rbs_in_if.sink     rec_in,
    rbs_out_if.source  rec_out
);
    import rbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rec_in.valid),
        .in_last   (rec_in.last_record),
        .in_ready  (rec_in.ready),
        .out_valid (rec_out.valid),
        .out_ready (rec_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rbs_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_key    (rec_in.sort_key),
        .in_tag    (rec_in.record_tag),
        .out_key   (rec_out.sorted_key),
        .out_tag   (rec_out.sorted_tag),
        .out_final (rec_out.final_output)
    );
endmodule
